>>> sv/sdka_pkg.sv
// sdka_pkg: shared types and constants for the sph density kernel accumulator
// holds widths, register indexes, reset values, sequencer state and control word
// no dependencies
package sdka_pkg;

   // capacity of one particle set
   localparam int MaxParticles = 256;

   // field widths
   localparam int PosW    = 16;
   localparam int RadW    = 8;
   localparam int AbsW    = 16;
   localparam int Dist2W  = 33;
   localparam int KernW   = 16;
   localparam int MulAW   = 32;
   localparam int MulBW   = 16;
   localparam int ProdW   = 48;
   localparam int SumW    = 63;
   localparam int CountW  = 13;
   localparam int CsrIdxW = 2;
   localparam int CsrDatW = 16;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_SAMPLE_X = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_SAMPLE_Y = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_RADIUS   = 2'd2;

   // configuration reset values
   localparam logic signed [PosW-1:0] SampleXReset = 16'sd1920;
   localparam logic signed [PosW-1:0] SampleYReset = 16'sd7200;
   localparam logic [RadW-1:0]        RadiusReset  = 8'd100;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DX,
      ST_DY,
      ST_RR,
      ST_KV,
      ST_V2,
      ST_V3,
      ST_ACC
   } state_type;

   // shared multiplier operand selection
   typedef enum logic [2:0] {
      MUL_DX,
      MUL_DY,
      MUL_RR,
      MUL_V2,
      MUL_V3
   } mul_sel_type;

   // control word from sequencer to datapath
   typedef struct packed {
      mul_sel_type mul_sel;
      logic        prod_keep;
      logic        d2_first;
      logic        d2_add;
      logic        v_load;
      logic        acc_fire;
      logic        busy;
   } ctl_type;

endpackage

>>> sv/sdka_mul.sv
// sdka_mul: shared 32x16 unsigned multiplier with operand selection
// and registered product; used for dx^2, dy^2, r^2, v^2 and v^3
// depends on sdka_pkg
module sdka_mul (
   input  logic                              clock,
   input  sdka_pkg::mul_sel_type             mul_sel,
   input  logic                              prod_keep,
   input  logic [sdka_pkg::AbsW-1:0]         abs_dx,
   input  logic [sdka_pkg::AbsW-1:0]         abs_dy,
   input  logic [sdka_pkg::RadW-1:0]         radius,
   input  logic [sdka_pkg::KernW-1:0]        kern_v,
   output logic [sdka_pkg::ProdW-1:0]        prod
);

   logic [sdka_pkg::MulAW-1:0] op_a;
   logic [sdka_pkg::MulBW-1:0] op_b;
   logic [sdka_pkg::ProdW-1:0] prod_ff;
   logic [sdka_pkg::ProdW-1:0] prod_in;

   // operand mux
   always_comb begin
      case (mul_sel)
         sdka_pkg::MUL_DX: begin
            op_a = sdka_pkg::MulAW'(abs_dx);
            op_b = abs_dx;
         end
         sdka_pkg::MUL_DY: begin
            op_a = sdka_pkg::MulAW'(abs_dy);
            op_b = abs_dy;
         end
         sdka_pkg::MUL_RR: begin
            op_a = sdka_pkg::MulAW'(radius);
            op_b = sdka_pkg::MulBW'(radius);
         end
         sdka_pkg::MUL_V2: begin
            op_a = sdka_pkg::MulAW'(kern_v);
            op_b = kern_v;
         end
         sdka_pkg::MUL_V3: begin
            op_a = prod_ff[sdka_pkg::MulAW-1:0];
            op_b = kern_v;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // product register, held while the accumulate step waits
   assign prod_in = sdka_pkg::ProdW'(op_a) * sdka_pkg::ProdW'(op_b);

   always_ff @(posedge clock) begin
      if (!prod_keep) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

>>> sv/sdka_seq.sv
// sdka_seq: sequencer stepping one particle through the shared multiplier
// produces the control word for the datapath
// depends on sdka_pkg
module sdka_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              hold,
   output sdka_pkg::ctl_type ctl
);

   sdka_pkg::state_type state_ff;
   sdka_pkg::state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sdka_pkg::ST_IDLE: if (start) state_in = sdka_pkg::ST_DX;
         sdka_pkg::ST_DX:   state_in = sdka_pkg::ST_DY;
         sdka_pkg::ST_DY:   state_in = sdka_pkg::ST_RR;
         sdka_pkg::ST_RR:   state_in = sdka_pkg::ST_KV;
         sdka_pkg::ST_KV:   state_in = sdka_pkg::ST_V2;
         sdka_pkg::ST_V2:   state_in = sdka_pkg::ST_V3;
         sdka_pkg::ST_V3:   state_in = sdka_pkg::ST_ACC;
         sdka_pkg::ST_ACC:  if (!hold) state_in = sdka_pkg::ST_IDLE;
         default:           state_in = sdka_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdka_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control outputs
   always_comb begin
      ctl          = '0;
      ctl.mul_sel  = sdka_pkg::MUL_DX;
      ctl.busy     = (state_ff != sdka_pkg::ST_IDLE);
      case (state_ff)
         sdka_pkg::ST_DX:  ctl.mul_sel = sdka_pkg::MUL_DX;
         sdka_pkg::ST_DY: begin
            ctl.mul_sel  = sdka_pkg::MUL_DY;
            ctl.d2_first = 1'b1;
         end
         sdka_pkg::ST_RR: begin
            ctl.mul_sel = sdka_pkg::MUL_RR;
            ctl.d2_add  = 1'b1;
         end
         sdka_pkg::ST_KV:  ctl.v_load   = 1'b1;
         sdka_pkg::ST_V2:  ctl.mul_sel  = sdka_pkg::MUL_V2;
         sdka_pkg::ST_V3:  ctl.mul_sel  = sdka_pkg::MUL_V3;
         sdka_pkg::ST_ACC: begin
            ctl.acc_fire  = !hold;
            ctl.prod_keep = hold;
         end
         default:          ctl.mul_sel  = sdka_pkg::MUL_DX;
      endcase
   end

endmodule

>>> sv/sph_density_kernel_accumulator.sv
// sph_density_kernel_accumulator: poly6-style density summation over a particle set
// top level with config registers, accumulators and result register
// depends on sdka_pkg, sdka_mul, sdka_seq
//
//  channel | direction | handshake            | word
//  req     | in        | req_valid/req_stall  | pos_x, pos_y, last
//  rsp     | out       | rsp_valid/rsp_stall  | density, particle_count
//  csr     | in        | csr_valid/csr_ready  | index, data (ready always high)
//
// each particle: accept, then seven steps through the one shared
// 32x16 multiplier (dx^2, dy^2, r^2, kernel value, v^2, v^3, accumulate)
// a particle marked last waits in the accumulate step while the result word
// is still held by rsp_stall; a new particle is taken while a result waits
// synchronous active-high reset clears the sums, the sequencer and rsp_valid
module sph_density_kernel_accumulator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sdka_pkg::PosW-1:0]    req_pos_x,
   input  logic signed [sdka_pkg::PosW-1:0]    req_pos_y,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sdka_pkg::SumW-1:0]           rsp_density,
   output logic [sdka_pkg::CountW-1:0]         rsp_particle_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sdka_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [sdka_pkg::CsrDatW-1:0]        csr_data
);

   sdka_pkg::ctl_type ctl;

   logic signed [sdka_pkg::PosW-1:0]   sample_x_ff;
   logic signed [sdka_pkg::PosW-1:0]   sample_y_ff;
   logic [sdka_pkg::RadW-1:0]          radius_ff;
   logic [sdka_pkg::AbsW-1:0]          abs_dx_ff;
   logic [sdka_pkg::AbsW-1:0]          abs_dy_ff;
   logic                               last_ff;
   logic [sdka_pkg::Dist2W-1:0]        d2_ff;
   logic [sdka_pkg::KernW-1:0]         v_ff;
   logic [sdka_pkg::KernW-1:0]         v_in;
   logic [sdka_pkg::SumW-1:0]          sum_ff;
   logic [sdka_pkg::SumW-1:0]          sum_in;
   logic [sdka_pkg::CountW-1:0]        count_ff;
   logic [sdka_pkg::CountW-1:0]        count_in;
   logic                               rsp_valid_ff;
   logic [sdka_pkg::SumW-1:0]          rsp_density_ff;
   logic [sdka_pkg::CountW-1:0]        rsp_count_ff;
   logic [sdka_pkg::ProdW-1:0]         prod;
   logic signed [sdka_pkg::PosW:0]     dx;
   logic signed [sdka_pkg::PosW:0]     dy;
   logic [sdka_pkg::PosW:0]            dx_mag;
   logic [sdka_pkg::PosW:0]            dy_mag;
   logic [23:0]                        r2;
   logic [23:0]                        r2_diff;
   logic [sdka_pkg::SumW:0]            sum_wide;
   logic                               req_accept;
   logic                               hold;
   logic                               has_room;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = ctl.busy;
   assign csr_ready  = 1'b1;
   assign hold       = last_ff && rsp_valid_ff && rsp_stall;

   // sequencer
   sdka_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (req_accept),
      .hold  (hold),
      .ctl   (ctl)
   );

   // shared multiplier
   sdka_mul u_mul (
      .clock     (clock),
      .mul_sel   (ctl.mul_sel),
      .prod_keep (ctl.prod_keep),
      .abs_dx    (abs_dx_ff),
      .abs_dy    (abs_dy_ff),
      .radius    (radius_ff),
      .kern_v    (v_ff),
      .prod      (prod)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_x_ff <= sdka_pkg::SampleXReset;
         sample_y_ff <= sdka_pkg::SampleYReset;
         radius_ff   <= sdka_pkg::RadiusReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sdka_pkg::CSR_SAMPLE_X: sample_x_ff <= csr_data;
            sdka_pkg::CSR_SAMPLE_Y: sample_y_ff <= csr_data;
            sdka_pkg::CSR_RADIUS:   radius_ff   <= csr_data[sdka_pkg::RadW-1:0];
            default: ;
         endcase
      end
   end

   // distance magnitudes, taken at accept
   assign dx     = (sdka_pkg::PosW+1)'(req_pos_x) - (sdka_pkg::PosW+1)'(sample_x_ff);
   assign dy     = (sdka_pkg::PosW+1)'(req_pos_y) - (sdka_pkg::PosW+1)'(sample_y_ff);
   assign dx_mag = dx[sdka_pkg::PosW] ? -dx : dx;
   assign dy_mag = dy[sdka_pkg::PosW] ? -dy : dy;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         abs_dx_ff <= dx_mag[sdka_pkg::AbsW-1:0];
         abs_dy_ff <= dy_mag[sdka_pkg::AbsW-1:0];
         last_ff   <= req_last;
      end
   end

   // squared distance, q.8
   always_ff @(posedge clock) begin
      if (ctl.d2_first) begin
         d2_ff <= sdka_pkg::Dist2W'(prod);
      end else if (ctl.d2_add) begin
         d2_ff <= d2_ff + sdka_pkg::Dist2W'(prod);
      end
   end

   // kernel value: radius squared minus squared distance, clamped and truncated
   assign r2      = {prod[15:0], 8'h00};
   assign r2_diff = r2 - d2_ff[23:0];
   assign v_in    = (d2_ff >= sdka_pkg::Dist2W'(r2)) ? '0 : r2_diff[23:8];

   always_ff @(posedge clock) begin
      if (ctl.v_load) begin
         v_ff <= v_in;
      end
   end

   // saturating accumulate, skipped once the set is full
   assign has_room = count_ff < sdka_pkg::CountW'(sdka_pkg::MaxParticles);
   assign sum_wide = (sdka_pkg::SumW+1)'(sum_ff) + (sdka_pkg::SumW+1)'(prod);

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (has_room) begin
         sum_in   = sum_wide[sdka_pkg::SumW] ? '1 : sum_wide[sdka_pkg::SumW-1:0];
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (ctl.acc_fire) begin
         if (last_ff) begin
            sum_ff   <= '0;
            count_ff <= '0;
         end else begin
            sum_ff   <= sum_in;
            count_ff <= count_in;
         end
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.acc_fire && last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.acc_fire && last_ff) begin
         rsp_density_ff <= sum_in;
         rsp_count_ff   <= count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_density        = rsp_density_ff;
   assign rsp_particle_count = rsp_count_ff;

   // checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("sequencer not busy after accepting a particle");

   a_count_capacity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_particle_count <= sdka_pkg::CountW'(sdka_pkg::MaxParticles))
      else $error("particle count beyond capacity");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_particle_count != '0)
      else $error("result with empty particle set");

   a_sum_capacity: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sdka_pkg::CountW'(sdka_pkg::MaxParticles))
      else $error("running count beyond capacity");

endmodule
